/* design/hdg_pkg.sv */
// Shared widths, constants, CORDIC angle table and stage payload types for the heading pipeline.
package hdg_pkg;

  // Quaternion component width, two integer bits (Q1.14 at 16 bits)
  localparam int QUAT_WIDTH = 16;
  localparam int QUAT_FRAC  = QUAT_WIDTH - 2;

  // Products of two components, rotation-matrix terms with headroom for the doubling
  localparam int PROD_W = 2 * QUAT_WIDTH;
  localparam int TERM_W = 2 * QUAT_WIDTH + 2;

  // CORDIC datapath: two guard bits cover the gain of about 1.65 on a vector of length < 2^(TERM_W-1)
  localparam int CORDIC_W     = TERM_W + 2;
  localparam int ANGLE_W      = 32;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = 16;
  localparam int CORDIC_STEPS = (CORDIC_ITERS < TABLE_LEN) ? CORDIC_ITERS : TABLE_LEN;

  // Heading formats
  localparam int CORR_W           = 9;
  localparam int HDG_W            = 16;
  localparam int CENTIDEG_TURN    = 36000;
  localparam int CENTIDEG_PER_DEG = 100;
  localparam int SCALE_W          = 16;                 // holds CENTIDEG_TURN
  localparam int MUL_W            = ANGLE_W + SCALE_W;  // binary angle times centidegrees per turn
  localparam int SUM_W            = HDG_W + 2;          // signed corrected sum before the wrap

  localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(1) << (ANGLE_W - 1);

  // atan(2^-n) in binary-angle units (2^32 per turn), rounded to nearest
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331, 32'd21354465,
    32'd10679838,  32'd5340245,   32'd2670163,   32'd1335087,  32'd667544,   32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,    32'd10430,    32'd5215,
    32'd2608,      32'd1304,      32'd652,       32'd326,      32'd163,      32'd81
  };

  typedef struct packed {
    logic signed [PROD_W-1:0] jj;
    logic signed [PROD_W-1:0] kk;
    logic signed [PROD_W-1:0] ij;
    logic signed [PROD_W-1:0] rk;
  } quat_prod_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] x;   // r11
    logic signed [TERM_W-1:0] y;   // -r21
  } rot_term_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [ANGLE_W-1:0]         z;
    logic                       zero;  // both terms were zero: yaw forced to 0
  } cordic_vec_t;

endpackage

/* design/hdg_matrix.sv */
// Front end: component products, rotation-matrix terms and half-plane folding, three stages.
module hdg_matrix import hdg_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [QUAT_WIDTH-1:0] quat_real,
  input  logic signed [QUAT_WIDTH-1:0] quat_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_j,
  input  logic signed [QUAT_WIDTH-1:0] quat_k,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cordic_vec_t                  out_vec
);

  localparam int NSTG = 3;
  localparam logic signed [TERM_W-1:0] ONE_TERM = TERM_W'(1) << (2 * QUAT_FRAC);

  logic [NSTG-1:0] valid_r;
  logic [NSTG:0]   adv;

  quat_prod_t  prod_r, prod_nxt;
  rot_term_t   term_r, term_nxt;
  cordic_vec_t vec_r, vec_nxt;

  logic signed [TERM_W-1:0] sq_sum;
  logic signed [TERM_W-1:0] cross_sum;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = ~valid_r[k] | adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[NSTG-1];
  assign out_vec   = vec_r;

  always_comb begin
    prod_nxt.jj = PROD_W'(quat_j) * PROD_W'(quat_j);
    prod_nxt.kk = PROD_W'(quat_k) * PROD_W'(quat_k);
    prod_nxt.ij = PROD_W'(quat_i) * PROD_W'(quat_j);
    prod_nxt.rk = PROD_W'(quat_real) * PROD_W'(quat_k);
  end

  always_comb begin
    sq_sum     = TERM_W'(prod_r.jj) + TERM_W'(prod_r.kk);
    cross_sum  = TERM_W'(prod_r.ij) + TERM_W'(prod_r.rk);
    term_nxt.x = ONE_TERM - (sq_sum <<< 1);
    term_nxt.y = -(cross_sum <<< 1);
  end

  // left half plane: turn by half a turn so the CORDIC sees x >= 0
  always_comb begin
    vec_nxt.zero = (term_r.x == '0) && (term_r.y == '0);
    if (term_r.x[TERM_W-1]) begin
      vec_nxt.x = -CORDIC_W'(term_r.x);
      vec_nxt.y = -CORDIC_W'(term_r.y);
      vec_nxt.z = HALF_TURN;
    end else begin
      vec_nxt.x = CORDIC_W'(term_r.x);
      vec_nxt.y = CORDIC_W'(term_r.y);
      vec_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) valid_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) prod_r <= prod_nxt;
    if (adv[1]) term_r <= term_nxt;
    if (adv[2]) vec_r  <= vec_nxt;
  end

endmodule

/* design/hdg_cordic.sv */
// Vectoring CORDIC, one registered micro-rotation per stage.
module hdg_cordic import hdg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cordic_vec_t in_vec,
  output logic        out_valid,
  input  logic        out_ready,
  output cordic_vec_t out_vec
);

  logic [CORDIC_STEPS-1:0] valid_r;
  logic [CORDIC_STEPS:0]   adv;
  cordic_vec_t             stage_r [CORDIC_STEPS];

  always_comb begin
    adv[CORDIC_STEPS] = out_ready;
    for (int k = CORDIC_STEPS - 1; k >= 0; k--) begin
      adv[k] = ~valid_r[k] | adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[CORDIC_STEPS-1];
  assign out_vec   = stage_r[CORDIC_STEPS-1];

  for (genvar n = 0; n < CORDIC_STEPS; n++) begin : g_step
    cordic_vec_t              src;
    cordic_vec_t              rot_nxt;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;

    if (n == 0) begin : g_first
      assign src = in_vec;
    end else begin : g_next
      assign src = stage_r[n-1];
    end

    assign xs = src.x >>> n;
    assign ys = src.y >>> n;

    // drive y towards zero, accumulate the angle turned
    always_comb begin
      rot_nxt.zero = src.zero;
      if (!src.y[CORDIC_W-1]) begin
        rot_nxt.x = src.x + ys;
        rot_nxt.y = src.y - xs;
        rot_nxt.z = src.z + ATAN_TURNS[n];
      end else begin
        rot_nxt.x = src.x - ys;
        rot_nxt.y = src.y + xs;
        rot_nxt.z = src.z - ATAN_TURNS[n];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[n]) stage_r[n] <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) valid_r[0] <= in_valid;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        if (adv[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

endmodule

/* design/hdg_scale.sv */
// Back end: binary angle to centidegrees, mounting correction and wrap into 0..35999.
module hdg_scale import hdg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cordic_vec_t              in_vec,
  input  logic signed [CORR_W-1:0] corr_deg,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [HDG_W-1:0]         heading
);

  localparam int NSTG = 3;
  localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(1) << (ANGLE_W - 1);

  logic [NSTG-1:0] valid_r;
  logic [NSTG:0]   adv;

  logic [ANGLE_W-1:0]      angle;
  logic [MUL_W-1:0]        prod_r, prod_nxt;
  logic [MUL_W-1:0]        rounded;
  logic [HDG_W-1:0]        cd_r, cd_nxt;
  logic signed [SUM_W-1:0] corr_cd;
  logic signed [SUM_W-1:0] sum;
  logic [HDG_W-1:0]        heading_r, heading_nxt;

  always_comb begin
    adv[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = ~valid_r[k] | adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[NSTG-1];
  assign heading   = heading_r;

  assign angle    = in_vec.zero ? '0 : in_vec.z;
  assign prod_nxt = MUL_W'(angle) * MUL_W'(CENTIDEG_TURN);

  // round half up; a full turn folds back to zero
  always_comb begin
    rounded = prod_r + ROUND_HALF;
    cd_nxt  = rounded[MUL_W-1:ANGLE_W];
    if (32'(cd_nxt) >= CENTIDEG_TURN) cd_nxt = '0;
  end

  // sum lies in (-36000, 72000): one correction either way
  always_comb begin
    corr_cd = SUM_W'(corr_deg) * SUM_W'(CENTIDEG_PER_DEG);
    sum     = SUM_W'(cd_r) + corr_cd;
    if (sum[SUM_W-1]) begin
      heading_nxt = HDG_W'(sum + SUM_W'(CENTIDEG_TURN));
    end else if ($unsigned(sum) >= SUM_W'(CENTIDEG_TURN)) begin
      heading_nxt = HDG_W'(sum - SUM_W'(CENTIDEG_TURN));
    end else begin
      heading_nxt = HDG_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) valid_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) prod_r    <= prod_nxt;
    if (adv[1]) cd_r      <= cd_nxt;
    if (adv[2]) heading_r <= heading_nxt;
  end

endmodule

/* design/quaternion_to_heading.sv */
// Top level: quaternion to compass heading pipeline with mounting correction register.
//
//   channel  direction  handshake               payload
//   in_      into       in_valid / in_ready     in_quat_real, in_quat_i, in_quat_j, in_quat_k
//   out_     out of     out_valid / out_ready   out_heading_centideg
//   cfg_     into       cfg_wr_en (no wait)     cfg_wr_data (correction in whole degrees)
//
// Throughput: one transfer per clock in and out while out_ready is high. The pipeline holds
// the front-end stages, one register stage per CORDIC micro-rotation and the back-end stages.
// Reset (rst_n low, synchronous) empties the pipeline and clears the correction to 0.
// Every stage holds its item while the next one is full and stalled; empty stages
// keep filling, so in_ready stays high while any bubble remains behind a stalled result.
// The correction is sampled in the last stage; write it only with the pipeline empty.
module quaternion_to_heading import hdg_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transfers
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_real,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_i,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_j,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_k,
  // result transfers
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [HDG_W-1:0]             out_heading_centideg,
  // correction register
  input  logic                         cfg_wr_en,
  input  logic signed [CORR_W-1:0]     cfg_wr_data
);

  logic signed [CORR_W-1:0] correction_r;

  // front end -> CORDIC
  logic        mtx_valid;
  logic        mtx_ready;
  cordic_vec_t mtx_vec;

  // CORDIC -> back end
  logic        cor_valid;
  logic        cor_ready;
  cordic_vec_t cor_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      correction_r <= '0;
    end else if (cfg_wr_en) begin
      correction_r <= cfg_wr_data;
    end
  end

  // r11 and -r21, folded into the right half plane
  hdg_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .quat_real (in_quat_real),
    .quat_i    (in_quat_i),
    .quat_j    (in_quat_j),
    .quat_k    (in_quat_k),
    .out_valid (mtx_valid),
    .out_ready (mtx_ready),
    .out_vec   (mtx_vec)
  );

  // yaw as a 32-bit binary angle
  hdg_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mtx_valid),
    .in_ready  (mtx_ready),
    .in_vec    (mtx_vec),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_vec   (cor_vec)
  );

  // centidegrees, correction, wrap; its last stage is the output register
  hdg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_vec    (cor_vec),
    .corr_deg  (correction_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .heading   (out_heading_centideg)
  );

  // an empty or draining output end means the whole chain can move
  a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> (in_ready && mtx_ready && cor_ready))
    else $error("pipeline back-pressured although the output end is moving");

  // results always lie within one turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_heading_centideg) < CENTIDEG_TURN))
    else $error("heading outside 0..35999");

  // a CORDIC result refused by the back end stays put until it is taken
  a_cordic_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cor_valid && !cor_ready) |=> (cor_valid && $stable(cor_vec)))
    else $error("CORDIC result changed while stalled");

endmodule
